FILE: design/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the shared widths, code constants and controller/datapath interface types.
// Depends on nothing.
`timescale 1ns / 1ps

package u8u16_pkg;

	// Widths and counts of the result buffer and its candidates.
	localparam int UNIT_W    = 16;
	localparam int MAX_UNITS = 4;
	localparam int IDX_W     = 2;
	localparam int CNT_W     = 3;
	localparam int NUM_CAND  = 6;

	// UTF-16 code constants.
	localparam logic [UNIT_W-1:0] REPLACEMENT  = 16'hFFFD;
	localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [20:0]       SUPP_BASE    = 21'h10000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] rd_idx;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CNT_W-1:0] n_units;
	} dp_sts_t;

endpackage

FILE: design/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_dpath and u8u16_ctrl.
//
// Channel  | Direction | tdata                 | tuser         | tlast
// ---------+-----------+-----------------------+---------------+--------
// s_axis   | in        | [7:0] data_byte       | has_byte      | last
// m_axis   | out       | [15:0] code_unit      | is_terminator | run_end
//
// An input transaction is decoded in the cycle it is taken; its results (zero to four
// units) leave the result buffer one per cycle while the output is ready, from the next
// cycle on. The next item is taken in the cycle the final result of the previous one is
// delivered. Reset clears the open sequence and the controller. A stall on the output
// holds the current unit and blocks the input.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tuser,   // is_terminator
	output logic        m_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing of transactions and results.
	u8u16_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_last  (m_tlast),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Decoding and result storage.
	u8u16_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_byte  (s_tdata),
		.in_has   (s_tuser),
		.in_last  (s_tlast),
		.sts      (sts),
		.unit_out (m_tdata),
		.term_out (m_tuser)
	);

endmodule

FILE: design/u8u16_dpath.sv
// Datapath of the UTF-8 to UTF-16 transcoder: sequence buffer, decoder and result buffer.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_dpath import u8u16_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [7:0]        in_byte,
	input  logic              in_has,
	input  logic              in_last,
	output dp_sts_t           sts,
	output logic [UNIT_W-1:0] unit_out,
	output logic              term_out
);

	// Sequence length of a lead byte; a byte that is no valid lead counts as one.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] r;
		if (b[7] == 1'b0)                r = 3'd1;
		else if (b[7:5] == 3'b110)       r = 3'd2;
		else if (b[7:4] == 4'b1110)      r = 3'd3;
		else if (b[7:3] == 5'b11110)     r = 3'd4;
		else                             r = 3'd1;
		return r;
	endfunction

	// Payload bits of a lead byte, or the replacement character for a bad lead.
	function automatic logic [UNIT_W-1:0] lead_bits(input logic [7:0] b);
		logic [UNIT_W-1:0] r;
		if (b[7] == 1'b0)                r = {8'd0, b};
		else if (b[7:5] == 3'b110)       r = {11'd0, b[4:0]};
		else if (b[7:4] == 4'b1110)      r = {12'd0, b[3:0]};
		else if (b[7:3] == 5'b11110)     r = {13'd0, b[2:0]};
		else                             r = REPLACEMENT;
		return r;
	endfunction

	logic [1:0]        cnt_q;
	logic [7:0]        pb0_q, pb1_q, pb2_q;
	logic [UNIT_W-1:0] unit_q [MAX_UNITS];
	logic              term_q [MAX_UNITS];

	logic [1:0]        cnt_mid, m;
	logic [7:0]        pb0_d, pb1_d, pb2_d;
	logic [2:0]        len_b, len_p, len_x, len_y;
	logic [UNIT_W-1:0] lb_p, lb_x, lb_y;
	logic [20:0]       cp_main, v;
	logic              main_v, big, flush, pair;
	logic [UNIT_W-1:0] hi_unit, lo_unit;
	logic [UNIT_W-1:0] cand_u [NUM_CAND];
	logic              cand_v [NUM_CAND];
	logic              cand_t [NUM_CAND];
	logic [UNIT_W-1:0] buf_u_d [MAX_UNITS];
	logic              buf_t_d [MAX_UNITS];
	logic [CNT_W-1:0]  n;

	// Byte handling: emit a lone byte at once, or start, extend or complete the open sequence.
	always_comb begin
		len_b   = lead_len(in_byte);
		len_p   = lead_len(pb0_q);
		lb_p    = lead_bits(pb0_q);
		pb0_d   = pb0_q;
		pb1_d   = pb1_q;
		pb2_d   = pb2_q;
		cp_main = '0;
		main_v  = 1'b0;
		cnt_mid = cnt_q;
		if (in_has) begin
			if (cnt_q == 2'd0) begin
				if (len_b == 3'd1) begin
					main_v  = 1'b1;
					cp_main = {5'd0, lead_bits(in_byte)};
				end else begin
					pb0_d   = in_byte;
					cnt_mid = 2'd1;
				end
			end else if (({1'b0, cnt_q} + 3'd1) >= len_p) begin
				main_v  = 1'b1;
				cnt_mid = 2'd0;
				unique case (cnt_q)
					2'd0: cp_main = '0;
					2'd1: cp_main = {10'd0, lb_p[4:0], in_byte[5:0]};
					2'd2: cp_main = {5'd0, lb_p[3:0], pb1_q[5:0], in_byte[5:0]};
					2'd3: cp_main = {lb_p[2:0], pb1_q[5:0], pb2_q[5:0], in_byte[5:0]};
				endcase
			end else begin
				if (cnt_q == 2'd1) pb1_d = in_byte;
				else               pb2_d = in_byte;
				cnt_mid = cnt_q + 2'd1;
			end
		end
	end

	// Surrogate pair split for code points above the basic plane.
	always_comb begin
		big     = |cp_main[20:16];
		v       = cp_main - SUPP_BASE;
		hi_unit = HI_SURR_BASE + {5'd0, v[20:10]};
		lo_unit = LO_SURR_BASE + {6'd0, v[9:0]};
	end

	// Candidate results in order: decoded unit(s), flush of an open sequence, terminator.
	always_comb begin
		flush = in_last && (cnt_mid != 2'd0);
		m     = cnt_mid - 2'd1;
		len_x = lead_len(pb1_d);
		len_y = lead_len(pb2_d);
		lb_x  = lead_bits(pb1_d);
		lb_y  = lead_bits(pb2_d);
		pair  = (len_x == 3'd2) && (m == 2'd2);

		for (int i = 0; i < NUM_CAND; i++) cand_t[i] = 1'b0;

		cand_v[0] = main_v;
		cand_u[0] = big ? hi_unit : cp_main[UNIT_W-1:0];
		cand_v[1] = main_v && big;
		cand_u[1] = lo_unit;
		cand_v[2] = flush;
		cand_u[2] = REPLACEMENT;

		// Held bytes after the lead are parsed again as a string tail.
		cand_v[3] = flush && (m != 2'd0);
		if (len_x == 3'd1)  cand_u[3] = lb_x;
		else if (pair)      cand_u[3] = {5'd0, lb_x[4:0], pb2_d[5:0]};
		else                cand_u[3] = REPLACEMENT;
		cand_v[4] = flush && (m == 2'd2) && !pair;
		cand_u[4] = (len_y == 3'd1) ? lb_y : REPLACEMENT;

		cand_v[5] = in_last;
		cand_u[5] = '0;
		cand_t[5] = 1'b1;
	end

	// Pack the valid candidates into the result buffer.
	always_comb begin
		for (int j = 0; j < MAX_UNITS; j++) begin
			buf_u_d[j] = '0;
			buf_t_d[j] = 1'b0;
		end
		n = '0;
		for (int i = 0; i < NUM_CAND; i++) begin
			if (cand_v[i]) begin
				if (n < CNT_W'(MAX_UNITS)) begin
					buf_u_d[n[IDX_W-1:0]] = cand_u[i];
					buf_t_d[n[IDX_W-1:0]] = cand_t[i];
				end
				n = n + CNT_W'(1);
			end
		end
		sts.n_units = n;
	end

	// Sequence count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (cmd.load) begin
			cnt_q <= in_last ? 2'd0 : cnt_mid;
		end
	end

	// Held bytes and result buffer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pb0_q <= pb0_d;
			pb1_q <= pb1_d;
			pb2_q <= pb2_d;
			for (int j = 0; j < MAX_UNITS; j++) begin
				unit_q[j] <= buf_u_d[j];
				term_q[j] <= buf_t_d[j];
			end
		end
	end

	assign unit_out = unit_q[cmd.rd_idx];
	assign term_out = term_q[cmd.rd_idx];

endmodule

FILE: design/u8u16_ctrl.sv
// Controller of the UTF-8 to UTF-16 transcoder: handshakes and result sequencing.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_ctrl import u8u16_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    out_last,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_unit, out_fire, in_fire;

	// Handshake decisions; a new item enters as the final result leaves.
	always_comb begin
		last_unit  = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;
		out_valid  = (state_q == ST_EMIT);
		out_fire   = out_valid && out_ready;
		in_ready   = (state_q == ST_IDLE) || (out_fire && last_unit);
		in_fire    = in_valid && in_ready;
		out_last   = last_unit;
		cmd.load   = in_fire;
		cmd.rd_idx = idx_q;
	end

	// State, result count and read index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			idx_q   <= '0;
		end else if (in_fire) begin
			state_q <= (sts.n_units != '0) ? ST_EMIT : ST_IDLE;
			n_q     <= sts.n_units;
			idx_q   <= '0;
		end else if (out_fire) begin
			if (last_unit) begin
				state_q <= ST_IDLE;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

FILE: tb/u8u16_checker.sv
// Result checker for the UTF-8 to UTF-16 transcoder testbench.
// Watches both stream channels, decodes each input transaction and compares the units.
// Depends on u8u16_pkg for the unit width and the UTF-16 code constants.
`timescale 1ns / 1ps

module u8u16_checker import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [15:0] code_unit
	input  logic        m_tuser,   // is_terminator
	input  logic        m_tlast,
	output int          error_count,
	output int          units_outstanding
);

	typedef struct packed {
		logic [UNIT_W-1:0] code;
		logic              term;
		logic              run_end;
	} utf16_unit_t;

	// Units still owed by the block, oldest first, and those of the item being decoded.
	utf16_unit_t expected_units[$];
	utf16_unit_t item_units[$];

	// Our own copy of the open UTF-8 sequence.
	logic [7:0] seq_bytes[3];
	logic [1:0] seq_count;

	int errors = 0;

	assign error_count = errors;

	// Number of bytes announced by a lead byte; a malformed lead stands alone.
	function automatic int unsigned seq_length(input logic [7:0] b);
		if (!b[7])
			return 1;
		if (b[7:5] == 3'b110)
			return 2;
		if (b[7:4] == 4'b1110)
			return 3;
		if (b[7:3] == 5'b11110)
			return 4;
		return 1;
	endfunction

	// Code point bits carried by a lead byte, or the replacement for a malformed lead.
	function automatic int unsigned lead_payload(input logic [7:0] b);
		if (!b[7])
			return 32'(b);
		if (b[7:5] == 3'b110)
			return 32'(b[4:0]);
		if (b[7:4] == 4'b1110)
			return 32'(b[3:0]);
		if (b[7:3] == 5'b11110)
			return 32'(b[2:0]);
		return 32'(REPLACEMENT);
	endfunction

	function automatic void push_unit(input int unsigned code, input logic term);
		utf16_unit_t u;
		u.code    = code[15:0];
		u.term    = term;
		u.run_end = 1'b0;
		item_units.insert(item_units.size(), u);
	endfunction

	// Supplementary code points split into a surrogate pair, high half first.
	function automatic void push_code_point(input int unsigned cp);
		int unsigned v;
		if (cp >= 32'(SUPP_BASE)) begin
			v = cp - 32'(SUPP_BASE);
			push_unit(32'(HI_SURR_BASE) + (v >> 10), 1'b0);
			push_unit(32'(LO_SURR_BASE) + (v & 32'h3FF), 1'b0);
		end else begin
			push_unit(cp, 1'b0);
		end
	endfunction

	// Works out the units that one input transaction causes and queues them.
	function automatic void decode_utf8_item(input logic [7:0] b, input logic has,
			input logic fin);
		int unsigned cnt, len, cp, i, m;
		item_units.delete();
		cnt = 32'(seq_count);

		// Take the byte: emit at once, open a sequence, extend it or complete it.
		if (has) begin
			if (cnt == 0) begin
				if (seq_length(b) == 1) begin
					push_code_point(lead_payload(b));
				end else begin
					seq_bytes[0] = b;
					cnt = 1;
				end
			end else begin
				len = seq_length(seq_bytes[0]);
				if (cnt + 1 >= len) begin
					cp = lead_payload(seq_bytes[0]);
					for (int k = 1; k < cnt; k++)
						cp = (cp << 6) | 32'(seq_bytes[k][5:0]);
					cp = (cp << 6) | 32'(b[5:0]);
					push_code_point(cp);
					cnt = 0;
				end else begin
					seq_bytes[cnt] = b;
					cnt++;
				end
			end
		end

		// End of string: replace the open lead, parse the held tail again, terminate.
		if (fin) begin
			if (cnt > 0) begin
				push_unit(32'(REPLACEMENT), 1'b0);
				m = cnt - 1;
				i = 0;
				while (i < m) begin
					len = seq_length(seq_bytes[1 + i]);
					cp  = lead_payload(seq_bytes[1 + i]);
					if (i + len > m) begin
						cp  = 32'(REPLACEMENT);
						len = 1;
					end else begin
						for (int k = 1; k < len; k++)
							cp = (cp << 6) | 32'(seq_bytes[1 + i + k][5:0]);
					end
					i += len;
					push_code_point(cp);
				end
				cnt = 0;
			end
			push_unit(0, 1'b1);
		end

		seq_count = cnt[1:0];
		if (item_units.size() > 0)
			item_units[item_units.size() - 1].run_end = 1'b1;
		foreach (item_units[j])
			expected_units.insert(expected_units.size(), item_units[j]);
	endfunction

	// Output transactions are compared before the input of the same edge is decoded.
	always @(posedge clk or negedge arst_n) begin
		utf16_unit_t want;
		if (!arst_n) begin
			expected_units.delete();
			seq_count = 2'd0;
			units_outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_units.size() == 0) begin
					$error("unexpected result: code_unit %h with nothing expected", m_tdata);
					errors++;
				end else begin
					want = expected_units.pop_front();
					if (m_tdata !== want.code) begin
						$error("code_unit mismatch: expected %h, actual %h", want.code, m_tdata);
						errors++;
					end
					if (m_tuser !== want.term) begin
						$error("is_terminator mismatch: expected %b, actual %b", want.term,
							m_tuser);
						errors++;
					end
					if (m_tlast !== want.run_end) begin
						$error("run_end mismatch: expected %b, actual %b", want.run_end, m_tlast);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_utf8_item(s_tdata, s_tuser, s_tlast);
			units_outstanding = expected_units.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// Top of the UTF-8 to UTF-16 transcoder testbench: clock, reset, stimulus and verdict.
// Depends on utf8_to_utf16_transcoder_unit, u8u16_checker and u8u16_pkg.
`timescale 1ns / 1ps

module tb_top;

	localparam int RANDOM_ITEMS = 120;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // has_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] code_unit
	logic        m_tuser;   // is_terminator
	logic        m_tlast;

	int error_count;
	int units_outstanding;
	int items_sent = 0;
	int cycle_count = 0;
	logic quiet = 1'b0;

	utf8_to_utf16_transcoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	u8u16_checker unit_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.m_tlast           (m_tlast),
		.error_count       (error_count),
		.units_outstanding (units_outstanding)
	);

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Runaway guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long; none during the quiet stretch.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver stalls.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Offers one item after a random gap and waits until it is taken.
	task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= has;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (has || fin)
			items_sent++;
	endtask

	// One string of random characters: mostly well formed, some truncated or stray bytes.
	task automatic send_random_string();
		logic [7:0] bytes[$];
		logic [7:0] r;
		int n_chars, kind, len, ncont;
		logic split_end;
		n_chars = $urandom_range(0, 6);
		repeat (n_chars) begin
			kind = $urandom_range(0, 9);
			r = 8'($urandom);
			len = 1;
			ncont = 0;
			case (kind)
				0, 1, 2: begin
					bytes.insert(bytes.size(), {1'b0, r[6:0]});
				end
				3, 4: begin
					len = 2;
					ncont = 1;
				end
				5, 6: begin
					len = 3;
					ncont = 2;
				end
				7: begin
					len = 4;
					ncont = 3;
				end
				8: begin
					len = $urandom_range(2, 4);
					ncont = $urandom_range(0, len - 2);
				end
				default: begin
					bytes.insert(bytes.size(), r);
				end
			endcase
			if (len == 2)
				bytes.insert(bytes.size(), {3'b110, r[4:0]});
			else if (len == 3)
				bytes.insert(bytes.size(), {4'b1110, r[3:0]});
			else if (len == 4)
				bytes.insert(bytes.size(), {5'b11110, r[2:0]});
			repeat (ncont) begin
				r = 8'($urandom);
				bytes.insert(bytes.size(), {2'b10, r[5:0]});
			end
		end

		split_end = (bytes.size() == 0) || ($urandom_range(0, 3) == 0);
		foreach (bytes[i]) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(bytes[i], 1'b1, !split_end && (i == bytes.size() - 1));
		end
		if (split_end)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Reset, directed strings, random strings, drain and verdict.
	initial begin
		int base;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// ASCII extremes, then one character of each sequence length.
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'hC2, 1'b1, 1'b0);
		send_item(8'hA9, 1'b1, 1'b0);
		send_item(8'hE2, 1'b1, 1'b0);
		send_item(8'h82, 1'b1, 1'b0);
		send_item(8'hAC, 1'b1, 1'b0);
		send_item(8'hF0, 1'b1, 1'b0);
		send_item(8'h9F, 1'b1, 1'b0);
		send_item(8'h98, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		// Malformed leads: a stray continuation and bytes above the four-byte range.
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hF8, 1'b1, 1'b0);
		// An item with neither byte nor end, then the end on its own.
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
		// Empty string.
		send_item(8'h00, 1'b0, 1'b1);
		// Highest four-byte code point with the end on its final byte.
		send_item(8'hF4, 1'b1, 1'b0);
		send_item(8'h8F, 1'b1, 1'b0);
		send_item(8'hBF, 1'b1, 1'b0);
		send_item(8'hBF, 1'b1, 1'b1);
		// End inside a four-byte sequence whose tail holds a whole two-byte character.
		send_item(8'hF0, 1'b1, 1'b0);
		send_item(8'hC3, 1'b1, 1'b0);
		send_item(8'hA9, 1'b1, 1'b1);
		// End inside a sequence whose tail holds two ASCII bytes: four units.
		send_item(8'hF0, 1'b1, 1'b0);
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'h42, 1'b1, 1'b1);
		// End inside a sequence whose tail is an unfinished lead.
		send_item(8'hE2, 1'b1, 1'b0);
		send_item(8'hE2, 1'b1, 1'b1);

		// Random strings, with a stretch free of idling on both sides in the middle.
		base = items_sent;
		while (items_sent < base + RANDOM_ITEMS) begin
			quiet = (items_sent >= base + 60) && (items_sent < base + 95);
			send_random_string();
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		// Wait until the checker has queued the units of the final transaction.
		@(posedge clk);
		while (units_outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0 && units_outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
